>>> rtl/islw_pkg.sv
package islw_pkg;

   // grid storage
   localparam int GRID_DEPTH = 256;
   localparam int ADDR_W     = $clog2(GRID_DEPTH);
   localparam int COUNT_W    = $clog2(GRID_DEPTH + 1);

   // fixed point
   localparam int FRAC_BITS  = 16;
   localparam int VALUE_W    = 32;
   localparam int WEIGHT_W   = 17;

   // field widths
   localparam int INDEX_W    = 8;
   localparam int UPPER_W    = 9;
   localparam int STATUS_W   = 2;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOUND_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOUND_VALUE  = 2'd2;

   // request kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BELOW_BOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BELOW_GRID  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ABOVE_GRID  = 2'd3;

   // divider handshake
   typedef struct packed {
      logic               start;
      logic [VALUE_W-1:0] num;
      logic [VALUE_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [FRAC_BITS-1:0] quot;
   } div_rsp_type;

endpackage

>>> rtl/islw_div.sv
module islw_div (
   input  logic                 clock,
   input  logic                 reset,
   input  islw_pkg::div_req_type div_req,
   output islw_pkg::div_rsp_type div_rsp
);
   import islw_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS);

   typedef enum logic {
      DV_IDLE,
      DV_RUN
   } dv_state_type;

   dv_state_type         state_ff;
   logic [VALUE_W-1:0]   rem_ff;
   logic [VALUE_W-1:0]   den_ff;
   logic [FRAC_BITS-1:0] quot_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 done_ff;

   logic [VALUE_W:0]     rem_shift;
   logic                 fits;
   logic [VALUE_W:0]     rem_in;

   // one restoring step per cycle; remainder stays below the divisor
   always_comb begin
      rem_shift = {rem_ff, 1'b0};
      fits      = rem_shift >= {1'b0, den_ff};
      rem_in    = fits ? (rem_shift - {1'b0, den_ff}) : rem_shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         case (state_ff)
            DV_IDLE: begin
               done_ff <= 1'b0;
               if (div_req.start) begin
                  rem_ff   <= div_req.num;
                  den_ff   <= div_req.den;
                  cnt_ff   <= CNT_W'(FRAC_BITS - 1);
                  state_ff <= DV_RUN;
               end
            end
            DV_RUN: begin
               rem_ff  <= rem_in[VALUE_W-1:0];
               quot_ff <= {quot_ff[FRAC_BITS-2:0], fits};
               if (cnt_ff == '0) begin
                  done_ff  <= 1'b1;
                  state_ff <= DV_IDLE;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            default: begin
               state_ff <= DV_IDLE;
            end
         endcase
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

>>> rtl/interval_search_lerp_weight.sv
// channel  | ports          | width          | contents
// req      | req_t*         | tdata 72, u 1  | load of one grid entry or a query
// rsp      | rsp_t*         | tdata 48, u 2  | weight, complement, upper index, status
// csr      | csr_*          | data 32        | grid_count, bound_enable, bound_value
//
// a load request writes the grid memory at acceptance
// a query runs a binary search of P probes (at most 9 for 256 entries) and a
// division; a bounded query skips both, an off-grid one skips the division
// a query is paced by the single grid memory read port, read once per probe,
// and the one-bit-per-cycle divider shared for all weights
// reset is synchronous; grid contents are not cleared and must be loaded
// a finished result waits in the output register while new loads are taken
module interval_search_lerp_weight (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // entry_index[7:0], grid_value[39:8], query_value[71:40]
   input  logic        req_tuser,  // kind
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // weight[16:0], comp_weight[33:17],
                                   // upper_index[42:34], zero[47:43]
   output logic [1:0]  rsp_tuser,  // status
   // configuration writes
   input  logic                             csr_we,
   input  logic [islw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [islw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import islw_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROBE,
      S_TEST,
      S_LO,
      S_HI,
      S_CHECK,
      S_DIV,
      S_DONE
   } state_type;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << FRAC_BITS);

   // configuration registers
   logic [COUNT_W-1:0]        grid_count_ff;
   logic                      bound_enable_ff;
   logic signed [VALUE_W-1:0] bound_value_ff;

   // request fields
   logic                      req_kind;
   logic [INDEX_W-1:0]        req_entry_index;
   logic signed [VALUE_W-1:0] req_grid_value;
   logic signed [VALUE_W-1:0] req_query_value;
   logic                      req_accept;

   // grid memory
   logic [VALUE_W-1:0]        grid_ff [GRID_DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]         rd_addr;

   // sequencer
   state_type                 state_ff;
   logic signed [VALUE_W-1:0] query_ff;
   logic [COUNT_W-1:0]        limit_ff;
   logic [COUNT_W-1:0]        first_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic [COUNT_W-1:0]        probe_ff;
   logic [COUNT_W-1:0]        step_ff;
   logic signed [VALUE_W-1:0] lo_ff;
   logic [COUNT_W-1:0]        limit_in;
   logic [COUNT_W-1:0]        probe_sum;

   // pending result
   logic [WEIGHT_W-1:0]       res_weight_ff;
   logic [WEIGHT_W-1:0]       res_comp_ff;
   logic [UPPER_W-1:0]        res_upper_ff;
   logic [STATUS_W-1:0]       res_status_ff;

   // output register
   logic                      rsp_tvalid_ff;
   logic [47:0]               rsp_tdata_ff;
   logic [STATUS_W-1:0]       rsp_tuser_ff;

   // bracket check and differences
   logic signed [VALUE_W:0]   num_wide;
   logic signed [VALUE_W:0]   den_wide;
   logic                      bracket_ok;

   div_req_type               div_req;
   div_rsp_type               div_rsp;

   assign req_kind        = req_tuser;
   assign req_entry_index = req_tdata[7:0];
   assign req_grid_value  = req_tdata[39:8];
   assign req_query_value = req_tdata[71:40];

   // nothing is taken while reset is held
   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign req_accept = req_tvalid && req_tready;

   // active count clamped to [2, GRID_DEPTH]
   always_comb begin
      if (grid_count_ff < COUNT_W'(2)) begin
         limit_in = COUNT_W'(2);
      end else if (grid_count_ff > COUNT_W'(GRID_DEPTH)) begin
         limit_in = COUNT_W'(GRID_DEPTH);
      end else begin
         limit_in = grid_count_ff;
      end
   end

   assign probe_sum = first_ff + (count_ff >> 1);

   always_comb begin
      case (state_ff)
         S_LO:    rd_addr = ADDR_W'(first_ff - 1'b1);
         S_HI:    rd_addr = first_ff[ADDR_W-1:0];
         default: rd_addr = probe_sum[ADDR_W-1:0];
      endcase
   end

   // in S_CHECK the read data is the upper entry
   always_comb begin
      num_wide   = {query_ff[VALUE_W-1], query_ff} - {lo_ff[VALUE_W-1], lo_ff};
      den_wide   = {rd_data_ff[VALUE_W-1], rd_data_ff} - {lo_ff[VALUE_W-1], lo_ff};
      bracket_ok = (rd_data_ff > lo_ff) && (query_ff >= lo_ff) && (query_ff < rd_data_ff);
   end

   assign div_req.start = (state_ff == S_CHECK) && bracket_ok;
   assign div_req.num   = num_wide[VALUE_W-1:0];
   assign div_req.den   = den_wide[VALUE_W-1:0];

   islw_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_count_ff   <= COUNT_W'(2);
         bound_enable_ff <= 1'b0;
         bound_value_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_COUNT:   grid_count_ff   <= csr_wdata[COUNT_W-1:0];
            CSR_BOUND_ENABLE: bound_enable_ff <= csr_wdata[0];
            CSR_BOUND_VALUE:  bound_value_ff  <= csr_wdata[VALUE_W-1:0];
            default: ;
         endcase
      end
   end

   // grid memory: one write port for loads, one registered read port
   always_ff @(posedge clock) begin
      if (req_accept && (req_kind == KIND_LOAD)) begin
         grid_ff[req_entry_index] <= req_grid_value;
      end
      rd_data_ff <= grid_ff[rd_addr];
   end

   // query sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // a result leaving with no new one behind it empties the register
         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_DONE)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_accept && (req_kind == KIND_QUERY)) begin
                  query_ff      <= req_query_value;
                  limit_ff      <= limit_in;
                  first_ff      <= '0;
                  count_ff      <= limit_in;
                  res_weight_ff <= '0;
                  res_comp_ff   <= '0;
                  if (bound_enable_ff && (req_query_value < bound_value_ff)) begin
                     // below the lower bound: no search
                     res_upper_ff  <= UPPER_W'(1);
                     res_status_ff <= ST_BELOW_BOUND;
                     state_ff      <= S_DONE;
                  end else begin
                     state_ff <= S_PROBE;
                  end
               end
            end
            S_PROBE: begin
               if (count_ff == '0) begin
                  // search finished, first_ff is the upper index
                  res_upper_ff <= UPPER_W'(first_ff);
                  if (first_ff == '0) begin
                     res_status_ff <= ST_BELOW_GRID;
                     state_ff      <= S_DONE;
                  end else if (first_ff >= limit_ff) begin
                     res_status_ff <= ST_ABOVE_GRID;
                     state_ff      <= S_DONE;
                  end else begin
                     res_status_ff <= ST_OK;
                     state_ff      <= S_LO;
                  end
               end else begin
                  probe_ff <= probe_sum;
                  step_ff  <= count_ff >> 1;
                  state_ff <= S_TEST;
               end
            end
            S_TEST: begin
               if (query_ff >= rd_data_ff) begin
                  first_ff <= probe_ff + 1'b1;
                  count_ff <= count_ff - step_ff - 1'b1;
               end else begin
                  count_ff <= step_ff;
               end
               state_ff <= S_PROBE;
            end
            S_LO: begin
               state_ff <= S_HI;
            end
            S_HI: begin
               lo_ff    <= rd_data_ff;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               // degenerate bracket keeps zero weights
               state_ff <= bracket_ok ? S_DIV : S_DONE;
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  res_weight_ff <= {1'b0, div_rsp.quot};
                  res_comp_ff   <= WEIGHT_ONE - {1'b0, div_rsp.quot};
                  state_ff      <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {5'b0, res_upper_ff, res_comp_ff, res_weight_ff};
                  rsp_tuser_ff  <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // a query holds off further requests until its result is queued
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_kind == KIND_QUERY)) |=> !req_tready)
      else $error("request taken while a query is in progress");

   // weight and complement add to one, or are both zero
   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_OK)) |->
         (({1'b0, rsp_tdata[16:0]} + {1'b0, rsp_tdata[33:17]}) == {1'b0, WEIGHT_ONE})
         || ((rsp_tdata[16:0] == '0) && (rsp_tdata[33:17] == '0)))
      else $error("weight and complement inconsistent");

   // flagged results carry zero weights; below-bound and below-grid ones their fixed index
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_OK)) |->
         (rsp_tdata[33:0] == '0)
         && ((rsp_tuser != ST_BELOW_BOUND) || (rsp_tdata[42:34] == UPPER_W'(1)))
         && ((rsp_tuser != ST_BELOW_GRID) || (rsp_tdata[42:34] == '0)))
      else $error("flagged result with bad weight or index");

   // the divider is only started from the bracket check
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("division finished outside the divide step");

endmodule
